FILE: hw/rtl/cxpc_pkg.sv
// ----------------------------------------------------------------------------
// cxpc_pkg
// shared types, register codes and the xorshift32 step for the pixel cipher
// ----------------------------------------------------------------------------
package cxpc_pkg;

  localparam int unsigned PIX_W   = 24;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [WORD_W-1:0] SEED_RST   = 32'd1;
  localparam logic [WORD_W-1:0] SECRET_RST = 32'd0;
  localparam logic [CNT_W-1:0]  SKIP_RST   = 24'd0;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_SEED   = 2'd0,
    REG_SECRET = 2'd1,
    REG_SKIP   = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic       mode;
    logic       first_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } out_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] secret_value;
    logic [CNT_W-1:0]  skip_count;
  } cfg_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_WARM = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;         // first pixel taken: latch it, load seed and skip count
    logic step;         // one warm-up step of the generator
    logic emit;         // produce a result into the output register
    logic src_latched;  // emit from the latched first pixel, chain the secret
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic out_free;
  } stat_t;

  function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] r);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = r ^ (r << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

FILE: hw/rtl/cxpc_regs.sv
// ----------------------------------------------------------------------------
// cxpc_regs
// apb register file holding seed, secret value and skip count
// ----------------------------------------------------------------------------
module cxpc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cxpc_pkg::ADDR_W-1:0] paddr,
  input  logic [cxpc_pkg::DATA_W-1:0] pwdata,
  output logic [cxpc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output cxpc_pkg::cfg_t              cfg
);

  cxpc_pkg::cfg_t     cfg_r;
  cxpc_pkg::cfg_t     cfg_nxt;
  cxpc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = cxpc_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        cxpc_pkg::REG_SEED:   cfg_nxt.seed         = pwdata;
        cxpc_pkg::REG_SECRET: cfg_nxt.secret_value = pwdata;
        cxpc_pkg::REG_SKIP:   cfg_nxt.skip_count   = pwdata[cxpc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cxpc_pkg::REG_SEED:   prdata = cfg_r.seed;
      cxpc_pkg::REG_SECRET: prdata = cfg_r.secret_value;
      cxpc_pkg::REG_SKIP:   prdata = {{(cxpc_pkg::DATA_W-cxpc_pkg::CNT_W){1'b0}},
                                      cfg_r.skip_count};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed         <= cxpc_pkg::SEED_RST;
      cfg_r.secret_value <= cxpc_pkg::SECRET_RST;
      cfg_r.skip_count   <= cxpc_pkg::SKIP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/cxpc_ctrl.sv
// ----------------------------------------------------------------------------
// cxpc_ctrl
// sequencer: takes items, runs the generator warm-up, triggers results
// ----------------------------------------------------------------------------
module cxpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_first,
  output logic              in_stall,
  input  cxpc_pkg::stat_t   stat,
  output cxpc_pkg::cmd_t    cmd
);

  cxpc_pkg::state_t state_r;
  cxpc_pkg::state_t state_nxt;
  logic             take;

  assign in_stall = !(rst_n && (state_r == cxpc_pkg::ST_IDLE) && stat.out_free);
  assign take     = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cxpc_pkg::ST_IDLE: if (take && in_first) state_nxt = cxpc_pkg::ST_WARM;
      cxpc_pkg::ST_WARM: if (stat.cnt_zero && stat.out_free) state_nxt = cxpc_pkg::ST_IDLE;
      default:           state_nxt = cxpc_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      cxpc_pkg::ST_IDLE: begin
        cmd.load = take && in_first;
        cmd.emit = take && !in_first;
      end
      cxpc_pkg::ST_WARM: begin
        cmd.step        = !stat.cnt_zero;
        cmd.emit        = stat.cnt_zero && stat.out_free;
        cmd.src_latched = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cxpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/cxpc_dp.sv
// ----------------------------------------------------------------------------
// cxpc_dp
// generator, chaining register, warm-up counter and output register
// ----------------------------------------------------------------------------
module cxpc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cxpc_pkg::cfg_t       cfg,
  input  cxpc_pkg::in_item_t   in_data,
  input  cxpc_pkg::cmd_t       cmd,
  output cxpc_pkg::stat_t      stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cxpc_pkg::out_item_t  out_data
);

  logic [cxpc_pkg::WORD_W-1:0] gen_r, gen_nxt;
  logic [cxpc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [cxpc_pkg::PIX_W-1:0]  prev_r, prev_nxt;
  logic [cxpc_pkg::PIX_W-1:0]  hold_px_r, hold_px_nxt;
  logic                        hold_mode_r, hold_mode_nxt;
  logic                        out_valid_r, out_valid_nxt;
  cxpc_pkg::out_item_t         out_r, out_nxt;

  logic [cxpc_pkg::WORD_W-1:0] gen_step;
  logic [cxpc_pkg::PIX_W-1:0]  live_px, px_sel, chain, res;
  logic                        mode_sel;

  assign gen_step = cxpc_pkg::xs_next(gen_r);
  assign live_px  = {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};
  assign px_sel   = cmd.src_latched ? hold_px_r : live_px;
  assign mode_sel = cmd.src_latched ? hold_mode_r : in_data.mode;
  assign chain    = cmd.src_latched ? cfg.secret_value[cxpc_pkg::PIX_W-1:0] : prev_r;
  assign res      = px_sel ^ chain ^ gen_step[cxpc_pkg::PIX_W-1:0];

  // cnt_zero, out_free
  assign stat = {(cnt_r == '0), (!out_valid_r || !out_stall)};

  always_comb begin
    gen_nxt       = gen_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    hold_px_nxt   = hold_px_r;
    hold_mode_nxt = hold_mode_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load) begin
      gen_nxt       = cfg.seed;
      cnt_nxt       = cfg.skip_count;
      hold_px_nxt   = live_px;
      hold_mode_nxt = in_data.mode;
    end
    if (cmd.step) begin
      gen_nxt = gen_step;
      cnt_nxt = cnt_r - {{(cxpc_pkg::CNT_W-1){1'b0}}, 1'b1};
    end
    if (cmd.emit) begin
      gen_nxt           = gen_step;
      prev_nxt          = mode_sel ? px_sel : res;
      out_nxt.out_blue  = res[7:0];
      out_nxt.out_green = res[15:8];
      out_nxt.out_red   = res[23:16];
      out_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= cxpc_pkg::SEED_RST;
      cnt_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gen_r       <= gen_nxt;
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_px_r   <= hold_px_nxt;
    hold_mode_r <= hold_mode_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/chained_xor_pixel_cipher.sv
// ----------------------------------------------------------------------------
// chained_xor_pixel_cipher
// xorshift32 keystream pixel cipher with ciphertext chaining
// ----------------------------------------------------------------------------
// Each item is one rgb pixel plus a mode bit (0 encrypt, 1 decrypt) and a
// first-pixel flag. The result is pixel ^ chain ^ keystream, where the
// keystream is the low 24 bits of the next xorshift32 word (shifts 13, 17, 5)
// and the chain is the previous ciphertext pixel, or the low 24 bits of
// secret_value on a first pixel. A pixel that is not first goes straight to
// the output register, so such items stream one per clock while the output
// is drained. A first pixel reloads the generator from seed and steps it
// skip_count times with the single xorshift unit, one step a cycle, and its
// result is emitted before the next item is taken. seed, secret_value and
// skip_count sit at byte addresses 0, 4 and 8 of the apb port and are picked
// up at the next first pixel; pready is tied high.
// ----------------------------------------------------------------------------
module chained_xor_pixel_cipher (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cxpc_pkg::in_item_t          in_data,
  // pixel result
  output logic                        out_valid,
  input  logic                        out_stall,
  output cxpc_pkg::out_item_t         out_data,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cxpc_pkg::ADDR_W-1:0] paddr,
  input  logic [cxpc_pkg::DATA_W-1:0] pwdata,
  output logic [cxpc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  cxpc_pkg::cfg_t  cfg;
  cxpc_pkg::cmd_t  cmd;
  cxpc_pkg::stat_t stat;

  // register file
  cxpc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: idle takes items, warm runs the skip steps for a first pixel
  cxpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_first (in_data.first_pixel),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // generator, chain and output register
  cxpc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/cxpc_checker.sv
// ----------------------------------------------------------------------------
// cxpc_checker
// port-level checks for the pixel cipher, bound to the top level
// ----------------------------------------------------------------------------
module cxpc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input cxpc_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input cxpc_pkg::out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no item taken while a result is blocked
  a_no_take_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("item taken while output blocked");

  // a pixel that is not first gives its result on the next cycle
  a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.first_pixel |=> out_valid)
    else $error("non-first pixel result missing");

  // a first pixel always sends the sequencer to the warm state, which stalls the input
  a_first_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.first_pixel |=> in_stall)
    else $error("item taken right after first pixel");

endmodule

bind chained_xor_pixel_cipher cxpc_checker u_cxpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
